>>> design/dsob_pkg.sv
// shared types, constants and the exp2 table for the detuned saw oscillator bank
package dsob_pkg;

    localparam logic [20:0] C4_Q12     = 21'd1071626;
    // ceil(2^24 / 3), exact floor division by three for values below 2^23
    localparam logic [22:0] DIV3_K     = 23'd5592406;
    localparam int          MUL_W      = 24;
    localparam int          FREQ_W     = 28;
    localparam int          SUM_W      = 20;
    localparam int          D_W        = 18;
    localparam logic [D_W-1:0] THREE_Q16 = 18'd196608;

    localparam int          CFG_IDX_W  = 2;
    localparam int          CFG_DATA_W = 18;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_KNOB = 2'd1;

    typedef struct packed {
        logic load_in;
        logic mul_lerp;
        logic set_m;
        logic mul_base;
        logic set_base;
        logic start_inc;
        logic div_step;
        logic take_inc;
        logic upd_phase;
        logic start_d;
        logic flat;
        logic take_d;
        logic mul_sq;
        logic mul_cu;
        logic mul_d3;
        logic set_poly;
        logic acc;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic f_big;
        logic div_done;
        logic trans;
        logic last_voice;
        logic out_free;
    } t_dp_stat;

    // 2^(k/16) in q16
    function automatic logic [17:0] exp2_q16(input logic [4:0] idx);
        logic [17:0] v;
        case (idx)
            5'd0:    v = 18'd65536;
            5'd1:    v = 18'd68438;
            5'd2:    v = 18'd71468;
            5'd3:    v = 18'd74632;
            5'd4:    v = 18'd77936;
            5'd5:    v = 18'd81386;
            5'd6:    v = 18'd84990;
            5'd7:    v = 18'd88752;
            5'd8:    v = 18'd92682;
            5'd9:    v = 18'd96785;
            5'd10:   v = 18'd101070;
            5'd11:   v = 18'd105545;
            5'd12:   v = 18'd110218;
            5'd13:   v = 18'd115098;
            5'd14:   v = 18'd120194;
            5'd15:   v = 18'd125515;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

endpackage

>>> design/dsob_ctrl.sv
// sequencer for the oscillator bank: per-sample and per-voice step order
module dsob_ctrl
    import dsob_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LERP = 4'd1;
    localparam logic [3:0] S_MIDX = 4'd2;
    localparam logic [3:0] S_BMUL = 4'd3;
    localparam logic [3:0] S_BASE = 4'd4;
    localparam logic [3:0] S_VF   = 4'd5;
    localparam logic [3:0] S_DIVI = 4'd6;
    localparam logic [3:0] S_PH   = 4'd7;
    localparam logic [3:0] S_TST  = 4'd8;
    localparam logic [3:0] S_DIVD = 4'd9;
    localparam logic [3:0] S_SQ   = 4'd10;
    localparam logic [3:0] S_CU   = 4'd11;
    localparam logic [3:0] S_D3   = 4'd12;
    localparam logic [3:0] S_POLY = 4'd13;
    localparam logic [3:0] S_ACC  = 4'd14;
    localparam logic [3:0] S_OUT  = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_LERP;
                end
            end
            S_LERP: begin
                o_cmd.mul_lerp = 1'b1;
                n_state        = S_MIDX;
            end
            S_MIDX: begin
                o_cmd.set_m = 1'b1;
                n_state     = S_BMUL;
            end
            S_BMUL: begin
                o_cmd.mul_base = 1'b1;
                n_state        = S_BASE;
            end
            S_BASE: begin
                o_cmd.set_base = 1'b1;
                n_state        = S_VF;
            end
            S_VF: begin
                o_cmd.start_inc = 1'b1;
                n_state         = i_stat.f_big ? S_PH : S_DIVI;
            end
            S_DIVI: begin
                if (!i_stat.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else begin
                    o_cmd.take_inc = 1'b1;
                    n_state        = S_PH;
                end
            end
            S_PH: begin
                o_cmd.upd_phase = 1'b1;
                n_state         = S_TST;
            end
            S_TST: begin
                if (i_stat.trans) begin
                    o_cmd.start_d = 1'b1;
                    n_state       = S_DIVD;
                end else begin
                    o_cmd.flat = 1'b1;
                    n_state    = S_ACC;
                end
            end
            S_DIVD: begin
                if (!i_stat.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else begin
                    o_cmd.take_d = 1'b1;
                    n_state      = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.mul_sq = 1'b1;
                n_state      = S_CU;
            end
            S_CU: begin
                o_cmd.mul_cu = 1'b1;
                n_state      = S_D3;
            end
            S_D3: begin
                o_cmd.mul_d3 = 1'b1;
                n_state      = S_POLY;
            end
            S_POLY: begin
                o_cmd.set_poly = 1'b1;
                n_state        = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_stat.last_voice ? S_OUT : S_VF;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> design/dsob_dp.sv
// datapath: config registers, pitch map, serial divider, shared multiplier, phases, mix
module dsob_dp
    import dsob_pkg::*;
#(
    parameter int VOICES     = 7,
    parameter int PHASE_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic signed [15:0]    i_pitch_cv,
    input  logic signed [16:0]    i_spread_cv,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [16:0]    o_mix
);

    localparam int PB = PHASE_BITS;
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int QW = (PB > D_W) ? PB : D_W;
    localparam int DW = (PB + 1 > 30) ? PB + 1 : 30;
    localparam int CW = $clog2(QW + 1);

    logic [17:0]              r_sample_rate;
    logic [12:0]              r_spread_knob;
    logic [3:0]               r_idx;
    logic [7:0]               r_lo;
    logic [4:0]               r_sh;
    logic signed [17:0]       r_spread;
    logic [17:0]              r_m;
    logic [2*MUL_W-1:0]       r_prod;
    logic signed [FREQ_W-1:0] r_f;
    logic [VW-1:0]            r_voice;
    logic [PB-1:0]            r_phase [VOICES];
    logic [PB:0]              r_inc;
    logic [PB-1:0]            r_ph;
    logic [DW-1:0]            r_rem;
    logic [DW-1:0]            r_div;
    logic [QW-1:0]            r_sin;
    logic [QW-1:0]            r_quo;
    logic [CW-1:0]            r_cnt;
    logic [D_W-1:0]           r_c;
    logic [19:0]              r_c2;
    logic signed [15:0]       r_vout;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_out_valid;
    logic [16:0]              r_mix;

    // pitch clamp and table position
    logic signed [15:0] pitch_c;
    logic [16:0]        pitch_q;
    always_comb begin
        if (i_pitch_cv < -16'sd16384) begin
            pitch_c = -16'sd16384;
        end else if (i_pitch_cv > 16'sd16384) begin
            pitch_c = 16'sd16384;
        end else begin
            pitch_c = i_pitch_cv;
        end
        pitch_q = {pitch_c[15], pitch_c} + 17'd16384;
    end

    logic [17:0] tab_a;
    logic [17:0] tab_b;
    logic [12:0] tab_diff;
    assign tab_a    = exp2_q16({1'b0, r_idx});
    assign tab_b    = exp2_q16({1'b0, r_idx} + 5'd1);
    assign tab_diff = 13'(tab_b - tab_a);

    // transition segment flags from the current phase and increment
    logic [PB+2:0] ph_x;
    logic [PB+2:0] inc_x;
    logic          seg1;
    logic          seg2;
    logic          seg3;
    logic          trans;
    assign ph_x  = {3'b000, r_ph};
    assign inc_x = {2'b00, r_inc};
    assign seg1  = ph_x < inc_x;
    assign seg2  = !seg1 && (ph_x < (inc_x << 1));
    assign seg3  = !seg1 && !seg2;
    assign trans = (r_inc != '0) && (ph_x < ((inc_x << 1) + inc_x));

    // shared multiplier
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [2*MUL_W-1:0] mul_p;
    logic [22:0]        div3_x;
    assign div3_x = seg2 ? {r_prod[37:16], 1'b0} : {1'b0, r_prod[37:16]};
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.mul_lerp) begin
            mul_a = MUL_W'(tab_diff);
            mul_b = MUL_W'(r_lo);
        end else if (i_cmd.mul_base) begin
            mul_a = MUL_W'(C4_Q12);
            mul_b = MUL_W'(r_m);
        end else if (i_cmd.mul_sq) begin
            mul_a = MUL_W'(r_c);
            mul_b = MUL_W'(r_c);
        end else if (i_cmd.mul_cu) begin
            mul_a = MUL_W'(r_prod[35:16]);
            mul_b = MUL_W'(r_c);
        end else if (i_cmd.mul_d3) begin
            mul_a = MUL_W'(div3_x);
            mul_b = MUL_W'(DIV3_K);
        end
    end
    assign mul_p = mul_a * mul_b;

    // base frequency rounding shift
    logic [39:0] base_rnd;
    logic [39:0] base_sh;
    assign base_rnd = {1'b0, r_prod[38:0]} + (40'd1 << (r_sh - 5'd1));
    assign base_sh  = base_rnd >> r_sh;

    logic [21:0] lerp_rnd;
    assign lerp_rnd = {1'b0, r_prod[20:0]} + 22'd128;

    // voice frequency against the sample rate
    logic [17:0]   sr_eff;
    logic [29:0]   den;
    logic [26:0]   f_pos;
    logic          f_big;
    assign sr_eff = (r_sample_rate == '0) ? 18'd1 : r_sample_rate;
    assign den    = {sr_eff, 12'd0};
    assign f_pos  = r_f[FREQ_W-1] ? '0 : r_f[26:0];
    assign f_big  = DW'(f_pos) >= DW'(den);

    // restoring divider step
    logic [DW:0] div_t;
    logic        div_ge;
    assign div_t  = {r_rem, r_sin[QW-1]};
    assign div_ge = div_t >= {1'b0, r_div};

    logic [PB:0] nph;
    assign nph = {1'b0, r_phase[r_voice]} + r_inc;

    // polynomial and voice output
    logic [22:0]        q3;
    logic signed [25:0] poly;
    logic signed [25:0] poly_r;
    logic [12:0]        saw2;
    assign q3   = r_prod[46:24];
    assign saw2 = r_ph[PB-1 -: 13];
    always_comb begin
        if (seg1) begin
            poly = 26'sd65536 - $signed({3'b000, q3});
        end else if (seg2) begin
            poly = $signed({3'b000, q3}) - 26'sd3 * $signed({6'd0, r_c2})
                 + 26'sd3 * $signed({8'd0, r_c});
        end else begin
            poly = $signed({3'b000, q3}) - 26'sd65536;
        end
        poly_r = (poly + 26'sd8) >>> 4;
    end

    logic [16:0] sat;
    always_comb begin
        if (r_sum > 20'sd65535) begin
            sat = 17'h0FFFF;
        end else if (r_sum < -20'sd65536) begin
            sat = 17'h10000;
        end else begin
            sat = r_sum[16:0];
        end
    end

    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_stat.f_big      = f_big;
    assign o_stat.div_done   = (r_cnt == '0);
    assign o_stat.trans      = trans;
    assign o_stat.last_voice = (r_voice == VW'(VOICES - 1));
    assign o_stat.out_free   = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_mix             = $signed(r_mix);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= 18'd48000;
            r_spread_knob <= '0;
            r_out_valid   <= 1'b0;
            r_cnt         <= '0;
            for (int v = 0; v < VOICES; v++) begin
                r_phase[v] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SAMPLE_RATE: r_sample_rate <= i_cfg_data;
                    CFG_SPREAD_KNOB: r_spread_knob <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.start_inc && !f_big) begin
                r_cnt <= CW'(PB);
            end else if (i_cmd.start_d) begin
                r_cnt <= CW'(D_W);
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt - CW'(1);
            end
            if (i_cmd.upd_phase) begin
                r_phase[r_voice] <= nph[PB] ? '0 : nph[PB-1:0];
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_idx    <= pitch_q[11:8];
            r_lo     <= pitch_q[7:0];
            r_sh     <= 5'd20 - {1'b0, pitch_q[15:12]};
            r_spread <= $signed({5'd0, r_spread_knob}) + 18'(i_spread_cv);
            r_sum    <= '0;
        end
        if (i_cmd.mul_lerp || i_cmd.mul_base || i_cmd.mul_sq || i_cmd.mul_cu
                || i_cmd.mul_d3) begin
            r_prod <= mul_p;
        end
        if (i_cmd.set_m) begin
            r_m <= tab_a + 18'(lerp_rnd[21:8]);
        end
        if (i_cmd.set_base) begin
            r_f     <= $signed({2'b00, base_sh[25:0]});
            r_voice <= '0;
        end
        if (i_cmd.start_inc) begin
            if (f_big) begin
                r_inc <= {1'b1, {PB{1'b0}}};
            end else begin
                r_rem <= DW'(f_pos);
                r_div <= DW'(den);
                r_sin <= '0;
                r_quo <= '0;
            end
        end
        if (i_cmd.start_d) begin
            r_rem <= DW'(r_ph >> 2);
            r_div <= DW'(r_inc);
            r_sin <= {r_ph[1:0], {(QW - 2){1'b0}}};
            r_quo <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? DW'(div_t - {1'b0, r_div}) : DW'(div_t);
            r_sin <= r_sin << 1;
            r_quo <= {r_quo[QW-2:0], div_ge};
        end
        if (i_cmd.take_inc) begin
            r_inc <= {1'b0, r_quo[PB-1:0]};
        end
        if (i_cmd.upd_phase) begin
            r_ph <= nph[PB] ? '0 : nph[PB-1:0];
        end
        if (i_cmd.take_d) begin
            r_c <= seg3 ? THREE_Q16 - r_quo[D_W-1:0] : r_quo[D_W-1:0];
        end
        if (i_cmd.mul_cu) begin
            r_c2 <= r_prod[35:16];
        end
        if (i_cmd.set_poly) begin
            r_vout <= $signed({3'b000, saw2}) + poly_r[15:0];
        end
        if (i_cmd.flat) begin
            r_vout <= $signed({3'b000, saw2}) - 16'sd4096;
        end
        if (i_cmd.acc) begin
            r_sum   <= r_sum + SUM_W'(r_vout);
            r_f     <= r_f + FREQ_W'(r_spread);
            r_voice <= r_voice + VW'(1);
        end
        if (i_cmd.load_out) begin
            r_mix <= sat;
        end
    end

endmodule

>>> design/detuned_saw_oscillator_bank_top.sv
// Detuned saw oscillator bank: one mix sample per pitch/spread pair. The block
// takes one item at a time; most of its time per sample goes to a one-bit-per-
// cycle restoring divider that each voice uses twice, once for its phase increment
// (PHASE_BITS steps, skipped at or above the sample rate) and once for the
// transition position (18 steps, only inside the three-sample transition). A
// finished mix waits in an output register, and the next sample is taken while
// it waits. The configuration port is always ready; write it only while the block
// is idle.
module detuned_saw_oscillator_bank_top
    import dsob_pkg::*;
#(
    parameter int VOICES     = 7,
    parameter int PHASE_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [15:0]    i_pitch_cv,
    input  logic signed [16:0]    i_spread_cv,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [16:0]    o_mix,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    dsob_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    dsob_dp #(
        .VOICES     (VOICES),
        .PHASE_BITS (PHASE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pitch_cv  (i_pitch_cv),
        .i_spread_cv (i_spread_cv),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_mix       (o_mix)
    );

endmodule
